// File: rtl/pfpr_pkg.sv
package pfpr_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BITS  = 20;
    localparam int PIN_BITS   = 8;
    localparam int IDX_BITS   = $clog2(NUM_FRAMES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int STAMP_BITS = 16;

    localparam logic [STAMP_BITS-1:0] REBASE_LIMIT = 16'd32000;
    localparam logic [PIN_BITS-1:0]   PIN_MAX      = '1;

    localparam logic [2:0] K_PIN   = 3'd0;
    localparam logic [2:0] K_UNPIN = 3'd1;
    localparam logic [2:0] K_DIRTY = 3'd2;
    localparam logic [2:0] K_FORCE = 3'd3;
    localparam logic [2:0] K_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALL_PINNED = 2'd1;
    localparam logic [1:0] ST_NOT_RES    = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW  = 2'd3;

    typedef struct packed {
        logic [2:0]           kind;
        logic [PAGE_BITS-1:0] page_number;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_BITS-1:0]  frame_index;
        logic                 hit;
        logic                 fetch;
        logic                 write_back;
        logic [PAGE_BITS-1:0] write_back_page;
        logic [1:0]           status;
        logic [PIN_BITS-1:0]  pin_count;
        logic                 is_dirty;
        logic [31:0]          reads_done;
        logic [31:0]          writes_done;
        logic                 last;
    } t_out_beat;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_REBASE = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_FLOUT  = 6'b100000
    } t_state;

endpackage

// File: rtl/page_frame_pool_replacer.sv
// Pin, unpin, mark dirty and force page walk the frame table before the result beat,
// with one frame-table memory read per cycle during the lookup walk.
// An eviction that re-bases the stamps adds a stamp-memory pass.
// Flush pool writes back one beat per valid, dirty, unpinned frame, the final one marked last.
// One request at a time; the result register lets the next request in while a beat waits.
// Reset (synchronous, active low) clears valid, dirty, pins, stamp clock and totals at once.
module page_frame_pool_replacer
    import pfpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(NUM_FRAMES);

    logic [PAGE_BITS-1:0]  mem_page  [NUM_FRAMES];
    logic [STAMP_BITS-1:0] mem_stamp [NUM_FRAMES];

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    t_in_beat              r_req;
    logic                  r_mode;
    logic [NUM_FRAMES-1:0] r_valid, n_valid;
    logic [NUM_FRAMES-1:0] r_dirty, n_dirty;
    logic [PIN_BITS-1:0]   r_pins [NUM_FRAMES];
    logic [PIN_BITS-1:0]   n_pins [NUM_FRAMES];
    logic [STAMP_BITS-1:0] r_clock, n_clock;
    logic [31:0]           r_reads, n_reads;
    logic [31:0]           r_writes, n_writes;
    logic                  r_rebased, n_rebased;
    logic                  r_ov;
    t_out_beat             r_out, n_out;

    logic                  r_cv;
    logic [IDX_BITS-1:0]   r_ci;
    logic [PAGE_BITS-1:0]  r_rd_page;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    logic                  r_hit, r_emp, r_vic;
    logic [IDX_BITS-1:0]   r_hit_f, r_emp_f, r_vic_f;
    logic [STAMP_BITS-1:0] r_best;
    logic [PAGE_BITS-1:0]  r_vic_page;

    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  pg_we, st_we;
    logic [IDX_BITS-1:0]   pg_waddr, st_waddr;
    logic [PAGE_BITS-1:0]  pg_wdata;
    logic [STAMP_BITS-1:0] st_wdata;
    logic                  emit, out_free;
    logic [NUM_FRAMES-1:0] flush_mask;
    logic                  above_any;
    logic [IDX_BITS-1:0]   cur;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign out_free    = !r_ov || i_out_ready;
    assign cur         = r_idx[IDX_BITS-1:0];

    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            flush_mask[i] = r_valid[i] && r_dirty[i] && (r_pins[i] == '0);
        end
        above_any = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (IDX_BITS'(i) > cur && flush_mask[i]) begin
                above_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_pins    = r_pins;
        n_clock   = r_clock;
        n_reads   = r_reads;
        n_writes  = r_writes;
        n_rebased = r_rebased;
        emit      = 1'b0;
        n_out     = '0;
        rd_en     = 1'b0;
        rd_addr   = cur;
        pg_we     = 1'b0;
        pg_waddr  = r_vic_f;
        pg_wdata  = r_req.page_number;
        st_we     = 1'b0;
        st_waddr  = r_vic_f;
        st_wdata  = r_clock;
        unique case (r_state)
            S_IDLE: begin
                n_rebased = 1'b0;
                n_idx     = '0;
                if (i_in_valid) begin
                    case (i_in_data.kind)
                        K_PIN, K_UNPIN, K_DIRTY, K_FORCE: n_state = S_SCAN;
                        K_FLUSH: n_state = S_FLUSH;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx != LAST_CNT) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_REBASE: begin
                if (r_idx != LAST_CNT) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state   = S_DECIDE;
                    n_rebased = 1'b1;
                end
                if (r_cv) begin
                    st_we    = 1'b1;
                    st_waddr = r_ci;
                    st_wdata = (r_rd_stamp > r_best) ? r_rd_stamp - r_best : '0;
                end
            end
            S_DECIDE: begin
                if (r_req.kind == K_PIN && !r_hit && !r_emp && r_vic && !r_rebased
                        && r_clock > REBASE_LIMIT) begin
                    n_clock = (r_clock > r_best) ? r_clock - r_best : '0;
                    n_idx   = '0;
                    n_state = S_REBASE;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    n_out.last = 1'b1;
                    if (r_req.kind == K_PIN) begin
                        if (r_hit) begin
                            if (r_pins[r_hit_f] != PIN_MAX) begin
                                n_pins[r_hit_f] = r_pins[r_hit_f] + 1'b1;
                            end
                            if (r_mode) begin
                                st_we    = 1'b1;
                                st_waddr = r_hit_f;
                                n_clock  = r_clock + 1'b1;
                            end
                            n_out.frame_index = r_hit_f;
                            n_out.hit         = 1'b1;
                            n_out.pin_count   = n_pins[r_hit_f];
                            n_out.is_dirty    = r_dirty[r_hit_f];
                        end else if (!r_emp && !r_vic) begin
                            n_out.status = ST_ALL_PINNED;
                        end else begin
                            if (r_emp) begin
                                pg_waddr = r_emp_f;
                            end else if (r_dirty[r_vic_f]) begin
                                n_writes              = r_writes + 1'b1;
                                n_out.write_back      = 1'b1;
                                n_out.write_back_page = r_vic_page;
                            end
                            pg_we             = 1'b1;
                            st_we             = 1'b1;
                            st_waddr          = pg_waddr;
                            n_clock           = r_clock + 1'b1;
                            n_valid[pg_waddr] = 1'b1;
                            n_dirty[pg_waddr] = 1'b0;
                            n_pins[pg_waddr]  = PIN_BITS'(1);
                            n_reads           = r_reads + 1'b1;
                            n_out.frame_index = pg_waddr;
                            n_out.fetch       = 1'b1;
                            n_out.pin_count   = PIN_BITS'(1);
                        end
                    end else if (!r_hit) begin
                        n_out.status = ST_NOT_RES;
                    end else begin
                        n_out.frame_index = r_hit_f;
                        case (r_req.kind)
                            K_UNPIN: begin
                                if (r_pins[r_hit_f] == '0) begin
                                    n_out.status = ST_UNDERFLOW;
                                end else begin
                                    n_pins[r_hit_f] = r_pins[r_hit_f] - 1'b1;
                                end
                            end
                            K_DIRTY: n_dirty[r_hit_f] = 1'b1;
                            default: begin
                                n_dirty[r_hit_f]      = 1'b0;
                                n_writes              = r_writes + 1'b1;
                                n_out.write_back      = 1'b1;
                                n_out.write_back_page = r_req.page_number;
                            end
                        endcase
                        n_out.pin_count = n_pins[r_hit_f];
                        n_out.is_dirty  = n_dirty[r_hit_f];
                    end
                end
            end
            S_FLUSH: begin
                if (r_idx == '0 && flush_mask == '0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_idx == LAST_CNT) begin
                    n_state = S_IDLE;
                end else if (flush_mask[cur]) begin
                    rd_en   = 1'b1;
                    n_state = S_FLOUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLOUT: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    n_dirty[cur]          = 1'b0;
                    n_writes              = r_writes + 1'b1;
                    n_out.frame_index     = cur;
                    n_out.write_back      = 1'b1;
                    n_out.write_back_page = r_rd_page;
                    n_out.last            = !above_any;
                    n_idx                 = r_idx + 1'b1;
                    n_state               = S_FLUSH;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out.reads_done  = n_reads;
        n_out.writes_done = n_writes;
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            mem_page[pg_waddr] <= pg_wdata;
        end
        if (st_we) begin
            mem_stamp[st_waddr] <= st_wdata;
        end
        if (rd_en) begin
            r_rd_page  <= mem_page[rd_addr];
            r_rd_stamp <= mem_stamp[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci <= rd_addr;
        if (emit) begin
            r_out <= n_out;
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
            r_hit <= 1'b0;
            r_emp <= 1'b0;
            r_vic <= 1'b0;
        end else if (r_state == S_SCAN && r_cv) begin
            if (r_valid[r_ci] && r_rd_page == r_req.page_number && !r_hit) begin
                r_hit   <= 1'b1;
                r_hit_f <= r_ci;
            end
            if (!r_valid[r_ci] && !r_emp) begin
                r_emp   <= 1'b1;
                r_emp_f <= r_ci;
            end
            if (r_valid[r_ci] && r_pins[r_ci] == '0 && (!r_vic || r_rd_stamp <= r_best)) begin
                r_vic      <= 1'b1;
                r_vic_f    <= r_ci;
                r_best     <= r_rd_stamp;
                r_vic_page <= r_rd_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_mode    <= 1'b0;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_pins    <= '{default: '0};
            r_clock   <= '0;
            r_reads   <= '0;
            r_writes  <= '0;
            r_rebased <= 1'b0;
            r_ov      <= 1'b0;
            r_cv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_valid   <= n_valid;
            r_dirty   <= n_dirty;
            r_pins    <= n_pins;
            r_clock   <= n_clock;
            r_reads   <= n_reads;
            r_writes  <= n_writes;
            r_rebased <= n_rebased;
            r_cv      <= rd_en;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_fetch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fetch) |-> (o_out_data.status == ST_OK))
        else $error("fetch beat with error status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == K_PIN) |=> !o_in_ready)
        else $error("pin request did not start a walk");

    a_reads_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reads != $past(r_reads)) |-> (r_reads == $past(r_reads) + 32'd1))
        else $error("read total moved by more than one");

endmodule
